// ===== src/rfdc_pkg.sv =====
// Shared types, constants and helper functions for the radio frame dewhiten/CRC/parse block.
// No dependencies; imported by every module of the block.
`default_nettype none
package rfdc_pkg;

	localparam int MAX_FRAME_BYTES = 64;
	localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);
	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int POS_W = (CNT_W > 7) ? CNT_W : 7;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'h0000;
	localparam logic [8:0] PN9_SEED = 9'h1ff;
	localparam logic [23:0] HDR_LEN_MASK = 24'h00001f;
	localparam logic [23:0] HDR_FLAGS_MASK = 24'h0000e0;
	localparam logic [7:0] HDR_NO_PAYLOAD = 8'h20;
	localparam logic [7:0] F3_SKIP = 8'h01;
	localparam logic [7:0] F3_TEMP = 8'h08;

	localparam logic [4:0] TAG_MSG_NUM = 5'd0;
	localparam logic [4:0] TAG_HDR_LEN = 5'd2;
	localparam logic [4:0] TAG_HDR_FLAGS = 5'd3;
	localparam logic [4:0] TAG_FLAGS3 = 5'd8;
	localparam logic [4:0] TAG_TEMP_TYPE = 5'd9;
	localparam logic [4:0] TAG_MSG_ID = 5'd11;
	localparam logic [4:0] TAG_HDR_CHECK = 5'd12;
	localparam logic [4:0] TAG_RETRY = 5'd13;
	localparam logic [4:0] TAG_TARGET_ACK = 5'd20;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_LONG  = 2'd1,
		ST_SHORT = 2'd2,
		ST_CRC   = 2'd3
	} status_t;

	typedef struct packed {
		status_t          st;
		logic [CNT_W-1:0] len;
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} wr_t;

	typedef struct packed {
		logic       rel;
		logic [4:0] off;
		logic [1:0] nbytes;
		logic       be;
	} field_info_t;

	function automatic logic [8:0] pn9_adv(input logic [8:0] s);
		logic [8:0] r;
		r = s;
		for (int k = 0; k < 8; k++) begin
			r = {r[0] ^ r[5], r[8:1]};
		end
		return r;
	endfunction

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
		end
		return r;
	endfunction

	// rel: offset counts from the position after flags3 and its optional part
	function automatic field_info_t field_info(input logic [4:0] tag);
		field_info_t f;
		unique case (tag)
			5'd0:    f = '{1'b0, 5'd2, 2'd1, 1'b0};
			5'd1:    f = '{1'b0, 5'd3, 2'd1, 1'b0};
			5'd2:    f = '{1'b0, 5'd4, 2'd1, 1'b0};
			5'd3:    f = '{1'b0, 5'd4, 2'd1, 1'b0};
			5'd4:    f = '{1'b0, 5'd5, 2'd3, 1'b0};
			5'd5:    f = '{1'b0, 5'd8, 2'd1, 1'b0};
			5'd6:    f = '{1'b0, 5'd9, 2'd1, 1'b0};
			5'd7:    f = '{1'b0, 5'd10, 2'd1, 1'b0};
			5'd8:    f = '{1'b0, 5'd11, 2'd1, 1'b0};
			5'd9:    f = '{1'b0, 5'd12, 2'd1, 1'b0};
			5'd10:   f = '{1'b0, 5'd13, 2'd2, 1'b0};
			5'd11:   f = '{1'b1, 5'd0, 2'd2, 1'b0};
			5'd12:   f = '{1'b1, 5'd2, 2'd2, 1'b1};
			5'd13:   f = '{1'b1, 5'd4, 2'd1, 1'b0};
			5'd14:   f = '{1'b1, 5'd5, 2'd2, 1'b0};
			5'd15:   f = '{1'b1, 5'd7, 2'd2, 1'b0};
			5'd16:   f = '{1'b1, 5'd9, 2'd2, 1'b0};
			5'd17:   f = '{1'b1, 5'd11, 2'd1, 1'b0};
			5'd18:   f = '{1'b1, 5'd12, 2'd1, 1'b0};
			5'd19:   f = '{1'b1, 5'd13, 2'd1, 1'b0};
			5'd20:   f = '{1'b1, 5'd14, 2'd2, 1'b0};
			default: f = '{1'b0, 5'd0, 2'd1, 1'b0};
		endcase
		return f;
	endfunction

endpackage
`default_nettype wire

// ===== src/rfdc_store.sv =====
// Frame byte store: one write port, one registered read port.
// Depends on rfdc_pkg.
`default_nettype none
module rfdc_store (
	input  wire                           clk,
	input  rfdc_pkg::wr_t                 wr,
	input  wire                           rd_en,
	input  wire  [rfdc_pkg::ADDR_W-1:0]   rd_addr,
	output logic [7:0]                    rd_data
);
	import rfdc_pkg::*;

	logic [7:0] mem_q [MAX_FRAME_BYTES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== src/rfdc_fifo.sv =====
// Two-entry command queue between the byte front end and the field sequencer.
// Depends on rfdc_pkg.
`default_nettype none
module rfdc_fifo (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  rfdc_pkg::cmd_t       cmd_in,
	input  wire                  pop,
	output rfdc_pkg::cmd_t       cmd_out,
	output logic                 empty,
	output logic                 full
);
	import rfdc_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign empty   = (cnt_q == 2'd0);
	assign full    = (cnt_q == 2'd2);
	assign cmd_out = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			ent_q[wp_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wp_q <= ~wp_q;
			end
			if (pop && !empty) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

endmodule
`default_nettype wire

// ===== src/rfdc_front.sv =====
// Byte front end: PN9 dewhitening, length check, CRC16, store writes, frame-end command.
// Depends on rfdc_pkg.
`default_nettype none
module rfdc_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  wire  [7:0]           frame_byte,
	input  wire                  frame_start,
	output rfdc_pkg::wr_t        wr,
	output logic                 push,
	output rfdc_pkg::cmd_t       cmd
);
	import rfdc_pkg::*;

	logic             active_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] len_q;
	logic [8:0]       lfsr_q;
	logic [15:0]      crc_q;
	logic [7:0]       prev_q;

	logic             act;
	logic [CNT_W-1:0] count_cur;
	logic [8:0]       lfsr_cur;
	logic [15:0]      crc_cur;
	logic [7:0]       b;
	logic [7:0]       len_cur;
	logic             first;
	logic             len_bad;
	logic             crc_run;
	logic             at_end;

	always_comb begin
		act       = frame_start || active_q;
		count_cur = frame_start ? '0 : count_q;
		lfsr_cur  = frame_start ? PN9_SEED : lfsr_q;
		crc_cur   = frame_start ? CRC_INIT : crc_q;
		b         = frame_byte ^ lfsr_cur[7:0];
		first     = (count_cur == '0);
		len_cur   = first ? b : 8'(len_q);
		len_bad   = first && ((b > 8'(MAX_FRAME_BYTES)) || (b < 8'd2));
		crc_run   = (9'(count_cur) + 9'd2) < 9'(len_cur);
		at_end    = (9'(count_cur) + 9'd1) >= 9'(len_cur);

		wr.en     = accept && act && !len_bad;
		wr.addr   = count_cur[ADDR_W-1:0];
		wr.data   = b;

		push      = accept && act && (len_bad || at_end);
		cmd.len   = len_cur[CNT_W-1:0];
		if (len_bad) begin
			cmd.st = (b < 8'd2) ? ST_SHORT : ST_LONG;
		end else if (crc_cur == {prev_q, b}) begin
			cmd.st = ST_OK;
		end else begin
			cmd.st = ST_CRC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			count_q  <= '0;
			len_q    <= '0;
			lfsr_q   <= PN9_SEED;
			crc_q    <= CRC_INIT;
		end else if (accept && act) begin
			lfsr_q  <= pn9_adv(lfsr_cur);
			count_q <= count_cur + CNT_W'(1);
			crc_q   <= crc_run ? crc_byte(crc_cur, b) : crc_cur;
			if (first) begin
				len_q <= b[CNT_W-1:0];
			end
			active_q <= !(len_bad || at_end);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && act) begin
			prev_q <= b;
		end
	end

endmodule
`default_nettype wire

// ===== src/rfdc_back.sv =====
// Field sequencer: emits the status item, then, for an OK frame, reads the store and assembles each field.
// Depends on rfdc_pkg.
`default_nettype none
module rfdc_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  rfdc_pkg::cmd_t               cmd,
	input  wire                          empty,
	output logic                         pop,
	output logic                         active,
	output logic                         rd_en,
	output logic [rfdc_pkg::ADDR_W-1:0]  rd_addr,
	input  wire  [7:0]                   rd_data,
	output logic                         valid,
	output logic [1:0]                   status,
	output logic [4:0]                   field_tag,
	output logic [23:0]                  field_value,
	output logic                         last
);
	import rfdc_pkg::*;

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_RD   = 4'b0010,
		B_ACC  = 4'b0100,
		B_EMIT = 4'b1000
	} bstate_t;

	bstate_t          state_q;
	logic [4:0]       tag_q;
	logic [1:0]       j_q;
	logic [23:0]      acc_q;
	logic [CNT_W-1:0] len_q;
	logic [7:0]       hdr_q;
	logic [7:0]       f3_q;
	logic             inr_q;

	logic             valid_q;
	logic [1:0]       status_q;
	logic [4:0]       tag_out_q;
	logic [23:0]      value_q;
	logic             last_q;

	field_info_t      info;
	logic [4:0]       pos;
	logic [POS_W-1:0] addr;
	logic [7:0]       d;
	logic [23:0]      acc_nxt;
	logic [23:0]      emit_val;
	logic [4:0]       tag_nxt;
	logic             final_f;

	assign valid       = valid_q;
	assign status      = status_q;
	assign field_tag   = tag_out_q;
	assign field_value = value_q;
	assign last        = last_q;
	assign active      = (state_q != B_IDLE);
	assign pop         = (state_q == B_IDLE) && !empty;
	assign rd_en       = (state_q == B_RD);
	assign rd_addr     = addr[ADDR_W-1:0];

	always_comb begin
		info = field_info(tag_q);
		priority if (f3_q == F3_SKIP) begin
			pos = 5'd13;
		end else if (f3_q == F3_TEMP) begin
			pos = 5'd15;
		end else begin
			pos = 5'd12;
		end
		addr = (info.rel ? POS_W'(pos) : '0) + POS_W'(info.off) + POS_W'(j_q);
		d    = inr_q ? rd_data : 8'h00;

		if (info.be) begin
			acc_nxt = {acc_q[15:0], d};
		end else begin
			unique case (j_q)
				2'd0:    acc_nxt = acc_q | {16'h0000, d};
				2'd1:    acc_nxt = acc_q | {8'h00, d, 8'h00};
				2'd2:    acc_nxt = acc_q | {d, 16'h0000};
				default: acc_nxt = acc_q;
			endcase
		end

		if (tag_q == TAG_HDR_LEN) begin
			emit_val = acc_q & HDR_LEN_MASK;
		end else if (tag_q == TAG_HDR_FLAGS) begin
			emit_val = acc_q & HDR_FLAGS_MASK;
		end else begin
			emit_val = acc_q;
		end

		final_f = 1'b0;
		priority if (tag_q == TAG_FLAGS3) begin
			tag_nxt = (acc_q[7:0] == F3_TEMP) ? TAG_TEMP_TYPE : TAG_MSG_ID;
		end else if (tag_q == TAG_HDR_CHECK) begin
			tag_nxt = TAG_RETRY;
			final_f = (hdr_q & HDR_NO_PAYLOAD) != 8'h00;
		end else if (tag_q == TAG_TARGET_ACK) begin
			tag_nxt = TAG_MSG_NUM;
			final_f = 1'b1;
		end else begin
			tag_nxt = tag_q + 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (!empty) begin
						valid_q <= 1'b1;
						state_q <= (cmd.st == ST_OK) ? B_RD : B_IDLE;
					end
				end
				B_RD:   state_q <= B_ACC;
				B_ACC:  state_q <= ((j_q + 2'd1) == info.nbytes) ? B_EMIT : B_RD;
				B_EMIT: begin
					valid_q <= 1'b1;
					state_q <= final_f ? B_IDLE : B_RD;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				status_q  <= cmd.st;
				tag_out_q <= TAG_MSG_NUM;
				value_q   <= '0;
				last_q    <= (cmd.st != ST_OK);
				len_q     <= cmd.len;
				tag_q     <= TAG_MSG_NUM;
				j_q       <= 2'd0;
				acc_q     <= '0;
				hdr_q     <= '0;
				f3_q      <= '0;
			end
			B_RD: begin
				inr_q <= addr < POS_W'(len_q);
			end
			B_ACC: begin
				acc_q <= acc_nxt;
				j_q   <= j_q + 2'd1;
			end
			B_EMIT: begin
				status_q  <= ST_OK;
				tag_out_q <= tag_q;
				value_q   <= emit_val;
				last_q    <= final_f;
				if (tag_q == TAG_HDR_LEN) begin
					hdr_q <= acc_q[7:0];
				end
				if (tag_q == TAG_FLAGS3) begin
					f3_q <= acc_q[7:0];
				end
				tag_q <= tag_nxt;
				j_q   <= 2'd0;
				acc_q <= '0;
			end
			default: begin
				j_q <= 2'd0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/radio_frame_dewhiten_crc_parse.sv =====
// Top level of the radio frame dewhiten/CRC/parse block.
// Depends on rfdc_pkg, rfdc_front, rfdc_fifo, rfdc_store, rfdc_back.
//
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------
// input    | start & !busy      | frame_byte[7:0], frame_start
// result   | valid (1 cycle)    | status[1:0], field_tag[4:0],
//          |                    | field_value[23:0], last
//
// A byte is taken when start is high and busy is low. At frame end (or on a
// bad length) busy rises while the sequencer drains: the status item, then,
// per field, a read and an accumulate state per stored byte and an emit state.
// The result side cannot stall; items leave as they are formed.
// After reset the block is idle and takes a start byte at once.
`default_nettype none
module radio_frame_dewhiten_crc_parse (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [7:0]  frame_byte,
	input  wire         frame_start,
	output logic        valid,
	output logic [1:0]  status,
	output logic [4:0]  field_tag,
	output logic [23:0] field_value,
	output logic        last
);
	import rfdc_pkg::*;

	wr_t               wr;
	logic              push;
	cmd_t              cmd_in;
	cmd_t              cmd_out;
	logic              pop;
	logic              empty;
	logic              full;
	logic              back_active;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        rd_data;
	logic              accept;

	assign busy   = !empty || full || back_active;
	assign accept = start && !busy;

	rfdc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.frame_byte  (frame_byte),
		.frame_start (frame_start),
		.wr          (wr),
		.push        (push),
		.cmd         (cmd_in)
	);

	rfdc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (cmd_in),
		.pop     (pop),
		.cmd_out (cmd_out),
		.empty   (empty),
		.full    (full)
	);

	rfdc_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	rfdc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_out),
		.empty       (empty),
		.pop         (pop),
		.active      (back_active),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.valid       (valid),
		.status      (status),
		.field_tag   (field_tag),
		.field_value (field_value),
		.last        (last)
	);

endmodule
`default_nettype wire
